FILE: hw/rtl/gcxt_pkg.sv
// Shared types, constants and helpers for the great-circle cross-track block.
// Depends on nothing; every other file of the block imports it.
package gcxt_pkg;

  // Iteration counts of the CORDIC and square-root chains.
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 31;

  // Latencies in register stages of the sub-units.
  localparam int SC_LAT = CORDIC_STEPS + 1;
  localparam int AT_LAT = CORDIC_STEPS + 4;
  localparam int SQ_LAT = SQRT_STEPS;

  localparam int ANGLE_BITS_DEF = 32;
  localparam int RADIUS_W       = 24;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd6373000;
  localparam int XT_W           = 29;

  // Q30 datapath word, CORDIC vectoring word, square-root words.
  localparam int Q_W     = 34;
  localparam int AT_W    = 36;
  localparam int SQ_W    = 63;
  localparam int SQ_IN_W = 61;
  localparam int ROOT_W  = 31;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [31:0] ang_t;

  // Tag that rides along the vectoring chain.
  typedef struct packed {
    logic base;
    logic zero;
  } at_tag_t;

  localparam q_t CORDIC_K = 34'sh0_26DD_3B6A;
  localparam q_t Q30_ONE  = 34'sd1073741824;
  localparam logic signed [31:0] HALF_PI     = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_HALF_PI = -32'sh4000_0000;
  localparam logic [27:0] PI_Q26 = 28'd210828714;
  localparam logic signed [XT_W-1:0] XT_MAX = 29'sd268435455;
  localparam logic signed [XT_W-1:0] XT_MIN = -29'sd268435456;

  // Arctangent of 2^-i as a binary angle.
  localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sh2000_0000, 32'sh12E4_051E, 32'sh09FB_385B, 32'sh0511_11D4, 32'sh028B_0D43,
    32'sh0145_D7E1, 32'sh00A2_F61E, 32'sh0051_7C55, 32'sh0028_BE53, 32'sh0014_5F2F,
    32'sh000A_2F98, 32'sh0005_17CC, 32'sh0002_8BE6, 32'sh0001_45F3, 32'sh0000_A2FA,
    32'sh0000_517D, 32'sh0000_28BE, 32'sh0000_145F, 32'sh0000_0A30, 32'sh0000_0518,
    32'sh0000_028C, 32'sh0000_0146, 32'sh0000_00A3, 32'sh0000_0051, 32'sh0000_0029,
    32'sh0000_0014, 32'sh0000_000A, 32'sh0000_0005, 32'sh0000_0003, 32'sh0000_0001
  };

  // Q30 product, rounded half up.
  function automatic q_t mulq(q_t a, q_t b);
    logic signed [2*Q_W-1:0] prod;
    prod = a * b + 68'sd536870912;
    return q_t'(prod >>> 30);
  endfunction

endpackage

FILE: hw/rtl/gcxt_rot_cell.sv
// One CORDIC micro-rotation with its output register, rotation or vectoring.
// Depends on gcxt_pkg for the arctangent table.
module gcxt_rot_cell import gcxt_pkg::*; #(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0,
  parameter int W      = Q_W,
  parameter int FW     = 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [31:0]  z_i,
  input  logic [FW-1:0]       f_i,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic signed [31:0]  z_o,
  output logic [FW-1:0]       f_o
);

  logic signed [W-1:0] x_r, y_r, dx, dy;
  logic signed [31:0]  z_r;
  logic [FW-1:0]       f_r;
  logic                dir;

  // Rotation follows the residual angle, vectoring drives y toward zero.
  always_comb begin
    dx  = x_i >>> STEP;
    dy  = y_i >>> STEP;
    dir = VECTOR ? !(y_i > 0) : (z_i >= 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dir) begin
        x_r <= x_i - dy;
        y_r <= y_i + dx;
        z_r <= z_i - ATAN_TAB[STEP];
      end else begin
        x_r <= x_i + dy;
        y_r <= y_i - dx;
        z_r <= z_i + ATAN_TAB[STEP];
      end
      f_r <= f_i;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
  assign f_o = f_r;

endmodule

FILE: hw/rtl/gcxt_sqrt_cell.sv
// One digit step of the integer square root, registered.
// Depends on gcxt_pkg for word widths.
module gcxt_sqrt_cell import gcxt_pkg::*; #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] v_i,
  input  logic [SQ_W-1:0] r_i,
  output logic [SQ_W-1:0] v_o,
  output logic [SQ_W-1:0] r_o
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

  logic [SQ_W-1:0] v_r, r_r, trial;

  assign trial = r_i + BIT;

  // Take the digit when the trial value fits into the remainder.
  always_ff @(posedge clk) begin
    if (en) begin
      if (v_i >= trial) begin
        v_r <= v_i - trial;
        r_r <= (r_i >> 1) + BIT;
      end else begin
        v_r <= v_i;
        r_r <= r_i >> 1;
      end
    end
  end

  assign v_o = v_r;
  assign r_o = r_r;

endmodule

FILE: hw/rtl/gcxt_delay.sv
// Enabled shift line that keeps side data aligned with the datapath.
// Depends on gcxt_pkg only by convention; optional clear for valid flags.
module gcxt_delay import gcxt_pkg::*; #(
  parameter int W   = 1,
  parameter int D   = 1,
  parameter bit CLR = 1'b0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    if (CLR && !rst_n) begin
      for (int i = 0; i < D; i++) sr_r[i] <= '0;
    end else if (en) begin
      sr_r[0] <= d_i;
      for (int i = 1; i < D; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q_o = sr_r[D-1];

endmodule

FILE: hw/rtl/gcxt_sincos.sv
// Pipelined sine and cosine of a binary angle: quadrant fold, CORDIC chain, sign fix.
// Depends on gcxt_pkg and gcxt_rot_cell.
module gcxt_sincos import gcxt_pkg::*; (
  input  logic clk,
  input  logic en,
  input  ang_t ang_i,
  output q_t   cos_o,
  output q_t   sin_o
);

  q_t                xs [CORDIC_STEPS+1];
  q_t                ys [CORDIC_STEPS+1];
  logic signed [31:0] zs [CORDIC_STEPS+1];
  logic [0:0]        fs [CORDIC_STEPS+1];
  ang_t              flip;
  q_t                cos_r, sin_r;

  // Angles past a quarter turn are turned by a half turn and negated at the end.
  always_comb begin
    flip  = ang_i + 32'h8000_0000;
    xs[0] = CORDIC_K;
    ys[0] = '0;
    if ($signed(ang_i) > HALF_PI || $signed(ang_i) < NEG_HALF_PI) begin
      zs[0] = $signed(flip);
      fs[0] = 1'b1;
    end else begin
      zs[0] = $signed(ang_i);
      fs[0] = 1'b0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    gcxt_rot_cell #(.STEP(i), .VECTOR(1'b0), .W(Q_W), .FW(1)) u_cell (
      .clk(clk), .en(en),
      .x_i(xs[i]), .y_i(ys[i]), .z_i(zs[i]), .f_i(fs[i]),
      .x_o(xs[i+1]), .y_o(ys[i+1]), .z_o(zs[i+1]), .f_o(fs[i+1])
    );
  end

  // Undo the half-turn fold.
  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= fs[CORDIC_STEPS][0] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
      sin_r <= fs[CORDIC_STEPS][0] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

FILE: hw/rtl/gcxt_atan2.sv
// Pipelined four-quadrant arctangent: half-plane fold, normalize, CORDIC vectoring.
// Depends on gcxt_pkg and gcxt_rot_cell.
module gcxt_atan2 import gcxt_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q_t   y_i,
  input  q_t   x_i,
  output ang_t ang_o
);

  q_t               xn, yn, yabs, mx;
  q_t               p1_x_r, p1_y_r, p2_x_r, p2_y_r;
  logic [Q_W-2:0]   p1_m_r;
  at_tag_t          p1_tag_r, p2_tag_r, p3_tag_r, tag_end;
  logic [4:0]       k, p2_k_r;
  logic signed [AT_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [AT_W-1:0] ys [CORDIC_STEPS+1];
  logic signed [31:0]     zs [CORDIC_STEPS+1];
  logic [1:0]             fs [CORDIC_STEPS+1];
  logic signed [AT_W-1:0] p3_x_r, p3_y_r;
  ang_t                   ang_r, base_ang;

  // Fold the left half-plane onto the right one and find the larger magnitude.
  always_comb begin
    xn   = (x_i < 0) ? -x_i : x_i;
    yn   = (x_i < 0) ? -y_i : y_i;
    yabs = (yn < 0) ? -yn : yn;
    mx   = (xn > yabs) ? xn : yabs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_x_r        <= xn;
      p1_y_r        <= yn;
      p1_m_r        <= mx[Q_W-2:0];
      p1_tag_r.base <= (x_i < 0);
      p1_tag_r.zero <= (xn == 0) && (yn == 0);
    end
  end

  // Doubling count that brings the larger part up to one in Q30.
  always_comb begin
    k = '0;
    if (p1_m_r < (Q_W-1)'(1 << 30)) begin
      for (int b = 0; b < 30; b++) begin
        if (p1_m_r[b]) k = 5'(30 - b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_x_r   <= p1_x_r;
      p2_y_r   <= p1_y_r;
      p2_k_r   <= k;
      p2_tag_r <= p1_tag_r;
    end
  end

  // Normalizing shift.
  always_ff @(posedge clk) begin
    if (en) begin
      p3_x_r   <= AT_W'(p2_x_r) <<< p2_k_r;
      p3_y_r   <= AT_W'(p2_y_r) <<< p2_k_r;
      p3_tag_r <= p2_tag_r;
    end
  end

  assign xs[0] = p3_x_r;
  assign ys[0] = p3_y_r;
  assign zs[0] = '0;
  assign fs[0] = p3_tag_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    gcxt_rot_cell #(.STEP(i), .VECTOR(1'b1), .W(AT_W), .FW(2)) u_cell (
      .clk(clk), .en(en),
      .x_i(xs[i]), .y_i(ys[i]), .z_i(zs[i]), .f_i(fs[i]),
      .x_o(xs[i+1]), .y_o(ys[i+1]), .z_o(zs[i+1]), .f_o(fs[i+1])
    );
  end

  // Add the half-turn offset; a zero vector gives the offset alone.
  always_comb begin
    tag_end  = at_tag_t'(fs[CORDIC_STEPS]);
    base_ang = {tag_end.base, 31'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= tag_end.zero ? base_ang : base_ang + ang_t'(zs[CORDIC_STEPS]);
    end
  end

  assign ang_o = ang_r;

endmodule

FILE: hw/rtl/gcxt_isqrt.sv
// Pipelined floor square root, one result bit per registered cell.
// Depends on gcxt_pkg and gcxt_sqrt_cell.
module gcxt_isqrt import gcxt_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SQ_IN_W-1:0] v_i,
  output logic [ROOT_W-1:0]  root_o
);

  logic [SQ_W-1:0] vs [SQRT_STEPS+1];
  logic [SQ_W-1:0] rs [SQRT_STEPS+1];

  assign vs[0] = SQ_W'(v_i);
  assign rs[0] = '0;

  // Digits from the top pair of bits down to the bottom pair.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    gcxt_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_cell (
      .clk(clk), .en(en),
      .v_i(vs[j]), .r_i(rs[j]),
      .v_o(vs[j+1]), .r_o(rs[j+1])
    );
  end

  assign root_o = rs[SQRT_STEPS][ROOT_W-1:0];

endmodule

FILE: hw/rtl/great_circle_cross_track_top.sv
// Great-circle cross-track distance engine, one word accepted per clock.
// The datapath is a chain of sine/cosine, arctangent and square-root cells;
// throughput is one word per cycle while in_stall is low.
// A two-entry output stage (register plus skid) lets the pipeline run on under a stall until the skid holds a word.
// Reset (rst_n, synchronous) clears all valid flags and loads the default radius.
// Depends on gcxt_pkg, gcxt_sincos, gcxt_atan2, gcxt_isqrt and gcxt_delay.
module great_circle_cross_track_top import gcxt_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         in_start_lat,
  input  logic signed [31:0]         in_start_lon,
  input  logic signed [31:0]         in_end_lat,
  input  logic signed [31:0]         in_end_lon,
  input  logic signed [31:0]         in_pos_lat,
  input  logic signed [31:0]         in_pos_lon,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [XT_W-1:0]     out_cross_track,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [RADIUS_W-1:0]        cfg_sphere_radius_m
);

  localparam ang_t KEEP = ~(32'hFFFF_FFFF >> ANGLE_BITS);
  localparam int PIPE_LAT = 1 + SC_LAT + 3 + AT_LAT + SC_LAT + 2 + SQ_LAT + AT_LAT + 4;

  // Slots of the first bank of sine/cosine units.
  localparam int N_SC     = 7;
  localparam int SC_DLP   = 0;
  localparam int SC_DLE   = 1;
  localparam int SC_SLAT  = 2;
  localparam int SC_PLAT  = 3;
  localparam int SC_ELAT  = 4;
  localparam int SC_HLAT  = 5;
  localparam int SC_HLON  = 6;

  logic adv;
  logic [RADIUS_W-1:0] radius_r;

  // Radius register; the port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_sphere_radius_m;
    end
  end

  // The whole pipeline moves while the skid stage is empty.
  logic skid_vld_r, out_vld_r;
  assign adv      = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // Input stage: truncate angles and form the differences.
  ang_t slat, slon, elat, elon, plat, plon;
  ang_t ang_r [N_SC];

  always_comb begin
    slat = ang_t'(in_start_lat) & KEEP;
    slon = ang_t'(in_start_lon) & KEEP;
    elat = ang_t'(in_end_lat) & KEEP;
    elon = ang_t'(in_end_lon) & KEEP;
    plat = ang_t'(in_pos_lat) & KEEP;
    plon = ang_t'(in_pos_lon) & KEEP;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r[SC_DLP]  <= plon - slon;
      ang_r[SC_DLE]  <= elon - slon;
      ang_r[SC_SLAT] <= slat;
      ang_r[SC_PLAT] <= plat;
      ang_r[SC_ELAT] <= elat;
      ang_r[SC_HLAT] <= (slat - plat) >> 1;
      ang_r[SC_HLON] <= (plon - slon) >> 1;
    end
  end

  q_t sc_cos [N_SC];
  q_t sc_sin [N_SC];

  for (genvar i = 0; i < N_SC; i++) begin : g_sc
    gcxt_sincos u_sc (
      .clk(clk), .en(adv), .ang_i(ang_r[i]), .cos_o(sc_cos[i]), .sin_o(sc_sin[i])
    );
  end

  // Products for both bearings and the haversine term.
  q_t m1_p1_r, m1_p2_r, m1_p3_r, m1_cdp_r, m1_q1_r, m1_q2_r, m1_q3_r, m1_cde_r;
  q_t m1_h1_r, m1_h2_r, m1_c0_r, m1_cp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_p1_r  <= mulq(sc_sin[SC_DLP], sc_cos[SC_PLAT]);
      m1_p2_r  <= mulq(sc_cos[SC_SLAT], sc_sin[SC_PLAT]);
      m1_p3_r  <= mulq(sc_sin[SC_SLAT], sc_cos[SC_PLAT]);
      m1_cdp_r <= sc_cos[SC_DLP];
      m1_q1_r  <= mulq(sc_sin[SC_DLE], sc_cos[SC_ELAT]);
      m1_q2_r  <= mulq(sc_cos[SC_SLAT], sc_sin[SC_ELAT]);
      m1_q3_r  <= mulq(sc_sin[SC_SLAT], sc_cos[SC_ELAT]);
      m1_cde_r <= sc_cos[SC_DLE];
      m1_h1_r  <= mulq(sc_sin[SC_HLAT], sc_sin[SC_HLAT]);
      m1_h2_r  <= mulq(sc_sin[SC_HLON], sc_sin[SC_HLON]);
      m1_c0_r  <= sc_cos[SC_SLAT];
      m1_cp_r  <= sc_cos[SC_PLAT];
    end
  end

  q_t m2_p1_r, m2_p2_r, m2_p4_r, m2_q1_r, m2_q2_r, m2_q4_r, m2_h1_r, m2_h3_r, m2_cp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_p4_r <= mulq(m1_p3_r, m1_cdp_r);
      m2_q4_r <= mulq(m1_q3_r, m1_cde_r);
      m2_h3_r <= mulq(m1_h2_r, m1_c0_r);
      m2_p1_r <= m1_p1_r;
      m2_p2_r <= m1_p2_r;
      m2_q1_r <= m1_q1_r;
      m2_q2_r <= m1_q2_r;
      m2_h1_r <= m1_h1_r;
      m2_cp_r <= m1_cp_r;
    end
  end

  q_t m3_yp_r, m3_xp_r, m3_ye_r, m3_xe_r, m3_h1_r, m3_h4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_yp_r <= m2_p1_r;
      m3_xp_r <= m2_p2_r - m2_p4_r;
      m3_ye_r <= m2_q1_r;
      m3_xe_r <= m2_q2_r - m2_q4_r;
      m3_h4_r <= mulq(m2_h3_r, m2_cp_r);
      m3_h1_r <= m2_h1_r;
    end
  end

  // Bearings from start to position and from start to end.
  ang_t b_pos, b_end;

  gcxt_atan2 u_at_pos (.clk(clk), .en(adv), .y_i(m3_yp_r), .x_i(m3_xp_r), .ang_o(b_pos));
  gcxt_atan2 u_at_end (.clk(clk), .en(adv), .y_i(m3_ye_r), .x_i(m3_xe_r), .ang_o(b_end));

  // Haversine term, clamped to the unit range, then both square roots.
  q_t hav_sum, hav_rest, m4_a_r;
  logic [SQ_IN_W-1:0] m5_va_r, m5_vb_r;

  assign hav_sum  = m3_h1_r + m3_h4_r;
  assign hav_rest = Q30_ONE - m4_a_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (hav_sum < 0) begin
        m4_a_r <= '0;
      end else if (hav_sum > Q30_ONE) begin
        m4_a_r <= Q30_ONE;
      end else begin
        m4_a_r <= hav_sum;
      end
      m5_va_r <= {m4_a_r[30:0], 30'b0};
      m5_vb_r <= {hav_rest[30:0], 30'b0};
    end
  end

  logic [ROOT_W-1:0] root_a, root_b, root_c;

  gcxt_isqrt u_sq_a (.clk(clk), .en(adv), .v_i(m5_va_r), .root_o(root_a));
  gcxt_isqrt u_sq_b (.clk(clk), .en(adv), .v_i(m5_vb_r), .root_o(root_b));

  // Sine of the central angle.
  q_t m6_sinc_r, sinc_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      m6_sinc_r <= mulq(q_t'(root_a), q_t'(root_b)) <<< 1;
    end
  end

  gcxt_delay #(.W(Q_W), .D(SC_LAT)) u_dl_sinc (
    .clk(clk), .rst_n(rst_n), .en(adv), .d_i(m6_sinc_r), .q_o(sinc_d)
  );

  // Sine of the bearing difference.
  q_t sdb;

  gcxt_sincos u_sc_db (
    .clk(clk), .en(adv), .ang_i(b_pos - b_end), .cos_o(), .sin_o(sdb)
  );

  // Cross-track sine, clamped, and the cosine term of the arcsine.
  q_t s_prod, s1_s_r, s2_s_r, s_d;
  logic signed [2*Q_W-1:0] s_sq, cq_v;
  logic [SQ_IN_W-1:0] s2_v_r;

  assign s_prod = mulq(sinc_d, sdb);
  assign s_sq   = s1_s_r * s1_s_r;
  assign cq_v   = (68'sd1 <<< 60) - s_sq;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s_prod > Q30_ONE) begin
        s1_s_r <= Q30_ONE;
      end else if (s_prod < -Q30_ONE) begin
        s1_s_r <= -Q30_ONE;
      end else begin
        s1_s_r <= s_prod;
      end
      s2_v_r <= cq_v[SQ_IN_W-1:0];
      s2_s_r <= s1_s_r;
    end
  end

  gcxt_isqrt u_sq_c (.clk(clk), .en(adv), .v_i(s2_v_r), .root_o(root_c));

  gcxt_delay #(.W(Q_W), .D(SQ_LAT)) u_dl_s (
    .clk(clk), .rst_n(rst_n), .en(adv), .d_i(s2_s_r), .q_o(s_d)
  );

  // Arcsine as an arctangent.
  ang_t u_ang, u_abs;

  gcxt_atan2 u_at_asin (.clk(clk), .en(adv), .y_i(s_d), .x_i(q_t'(root_c)), .ang_o(u_ang));

  // Scale the angle to sixteenths of a meter.
  logic [55:0] f1_mag_r;
  logic        f1_neg_r, f2_neg_r, f3_neg_r;
  logic [45:0] f2_ph_r, f2_pl_r;
  logic [35:0] mag_hi;
  logic [64:0] f3_tot;
  logic [31:0] f3_dist_r;
  logic signed [XT_W-1:0] f4_xt_r;

  assign u_abs  = u_ang[31] ? (32'd0 - u_ang) : u_ang;
  assign mag_hi = f1_mag_r[55:20];
  assign f3_tot = {1'b0, f2_ph_r, 18'b0} + 65'(f2_pl_r) + (65'd1 << 32);

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_mag_r  <= u_abs * radius_r;
      f1_neg_r  <= u_ang[31];
      f2_ph_r   <= mag_hi[35:18] * PI_Q26;
      f2_pl_r   <= mag_hi[17:0] * PI_Q26;
      f2_neg_r  <= f1_neg_r;
      f3_dist_r <= f3_tot[64:33];
      f3_neg_r  <= f2_neg_r;
      if (f3_neg_r) begin
        f4_xt_r <= (f3_dist_r > 32'd268435456) ? XT_MIN :
                   XT_W'(-$signed({1'b0, f3_dist_r}));
      end else begin
        f4_xt_r <= (f3_dist_r > 32'd268435455) ? XT_MAX : XT_W'(f3_dist_r);
      end
    end
  end

  // Valid flags ride alongside the datapath.
  logic vld_last;

  gcxt_delay #(.W(1), .D(PIPE_LAT), .CLR(1'b1)) u_dl_vld (
    .clk(clk), .rst_n(rst_n), .en(adv), .d_i(in_valid), .q_o(vld_last)
  );

  // Output register with a skid word behind it.
  logic signed [XT_W-1:0] out_xt_r, skid_xt_r;
  logic out_free;

  assign out_free = !out_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= vld_last;
      end
    end else if (!skid_vld_r && vld_last) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_xt_r <= skid_vld_r ? skid_xt_r : f4_xt_r;
    end else if (!skid_vld_r) begin
      skid_xt_r <= f4_xt_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_cross_track = out_xt_r;

  // The skid word is only ever occupied behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word held without an output word");

  // The skid word fills only when the output was stalled.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && out_stall))
    else $error("skid word filled without a stall");

  // A drained skid word moves into the output register.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_stall) |=> (out_vld_r && !skid_vld_r))
    else $error("skid word lost on drain");

  // Nothing advances into the output side while the skid word is held.
  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_stall) |=> $stable(f4_xt_r))
    else $error("pipeline moved while stalled");

endmodule

FILE: sim/great_circle_cross_track_top_tb.sv
// Self-checking testbench for great_circle_cross_track_top: cross-track distances
// predicted in fixed point here and compared with every output word. Needs gcxt_pkg.
module great_circle_cross_track_top_tb;
  import gcxt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 220;
  localparam logic [31:0] DEG90 = 32'h4000_0000;
  localparam logic [31:0] DEG180 = 32'h8000_0000;

  typedef struct {
    logic [31:0] slat, slon, elat, elon, plat, plon;
  } track_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_start_lat = '0, in_start_lon = '0, in_end_lat = '0;
  logic signed [31:0] in_end_lon = '0, in_pos_lat = '0, in_pos_lon = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [XT_W-1:0] out_cross_track;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RADIUS_W-1:0] cfg_sphere_radius_m = '0;

  // Model copy of the radius register and the queue of predicted distances.
  logic [RADIUS_W-1:0] radius_m = RADIUS_RST;
  logic signed [XT_W-1:0] xt_expected[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int n_words = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_cfg = 0;

  great_circle_cross_track_top DUT (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_start_lat, .in_start_lon, .in_end_lat, .in_end_lon, .in_pos_lat, .in_pos_lon,
    .out_valid, .out_stall, .out_cross_track,
    .cfg_valid, .cfg_ready, .cfg_sphere_radius_m
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint as_signed(logic [31:0] a);
    return longint'($signed(a));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rotation-mode CORDIC; angles past a right angle are folded by a half turn.
  function automatic void sin_cos(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = as_signed(ang);
    x = longint'(CORDIC_K);
    y = 0;
    flip = 0;
    if (z > (64'sd1 << 30) || z < -(64'sd1 << 30)) begin
      z = as_signed(ang + DEG180);
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Vectoring-mode CORDIC with normalization up to Q30 magnitude.
  function automatic logic [31:0] arc_tan2(longint y, longint x);
    logic [31:0] base;
    longint z, dx, dy;
    base = '0;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; base = DEG180;
    end
    if (x == 0 && y == 0) return base;
    while (x < 64'sd1073741824 && y < 64'sd1073741824 && y > -64'sd1073741824) begin
      x = x * 2; y = y * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    return base + z[31:0];
  endfunction

  function automatic logic [31:0] initial_bearing(logic [31:0] lat0, logic [31:0] lon0,
                                                  logic [31:0] lat1, logic [31:0] lon1);
    longint cd, sd, c0, s0, c1, s1;
    sin_cos(lon1 - lon0, cd, sd);
    sin_cos(lat0, c0, s0);
    sin_cos(lat1, c1, s1);
    return arc_tan2(qmul(sd, c1), qmul(c0, s1) - qmul(qmul(s0, c1), cd));
  endfunction

  function automatic logic signed [XT_W-1:0] cross_track_dist(track_word_t w,
                                                              logic [RADIUS_W-1:0] r);
    logic [31:0] b_pos, b_end;
    longint c0, s0, c1, s1, tmp, sh, sl, a, sinc, sdb, s, u;
    longint unsigned ra, rb, cq, mag, arc_len;
    b_pos = initial_bearing(w.slat, w.slon, w.plat, w.plon);
    b_end = initial_bearing(w.slat, w.slon, w.elat, w.elon);
    sin_cos(w.slat, c0, s0);
    sin_cos(w.plat, c1, s1);
    sin_cos((w.slat - w.plat) >> 1, tmp, sh);
    sin_cos((w.plon - w.slon) >> 1, tmp, sl);
    // Haversine term, then sin of the central angle.
    a = qmul(sh, sh) + qmul(qmul(qmul(sl, sl), c0), c1);
    if (a < 0) a = 0;
    if (a > 64'sd1073741824) a = 64'sd1073741824;
    ra = int_sqrt(longint'(a) << 30);
    rb = int_sqrt((64'sd1073741824 - a) << 30);
    sinc = 2 * qmul(longint'(ra), longint'(rb));
    sin_cos(b_pos - b_end, tmp, sdb);
    s = qmul(sinc, sdb);
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    if (s < -64'sd1073741824) s = -64'sd1073741824;
    cq = int_sqrt((64'd1 << 60) - longint'(s * s));
    u = as_signed(arc_tan2(s, longint'(cq)));
    // Angle to arc length, then saturate to the output field.
    mag = longint'(u < 0 ? -u : u) * longint'(r);
    arc_len = ((mag >> 20) * 64'd210828714 + (64'd1 << 32)) >> 33;
    if (u < 0) return arc_len > 64'd268435456 ? XT_MIN : XT_W'(-longint'(arc_len));
    return arc_len > 64'd268435455 ? XT_MAX : XT_W'(arc_len);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Checks each accepted output word and drives the result-side stall.
  always @(posedge clk) begin
    int hold_left;
    logic signed [XT_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (xt_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected word cross_track=%0d", out_cross_track));
      end else begin
        want = xt_expected.pop_front();
        if (out_cross_track !== want)
          report_mismatch($sformatf("cross_track got %0d want %0d", out_cross_track, want));
      end
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offers one word with random idle gaps and books its prediction on acceptance.
  task automatic send_word(track_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_lat <= w.slat; in_start_lon <= w.slon;
    in_end_lat <= w.elat;   in_end_lon <= w.elon;
    in_pos_lat <= w.plat;   in_pos_lon <= w.plon;
    do @(posedge clk); while (in_stall);
    xt_expected.push_back(cross_track_dist(w, radius_m));
    n_words++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (xt_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] r);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_sphere_radius_m <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radius_m = r;
    n_cfg++;
  endtask

  function automatic track_word_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                     logic [31:0] d, logic [31:0] e, logic [31:0] f);
    track_word_t w;
    w.slat = a; w.slon = b; w.elat = c; w.elon = d; w.plat = e; w.plon = f;
    return w;
  endfunction

  // Mostly realistic short tracks with random content, the rest raw noise.
  function automatic track_word_t random_track();
    track_word_t w;
    int unsigned span;
    if ($urandom_range(99) < 30)
      return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    span = 32'd1 << $urandom_range(30, 12);
    w.slat = $urandom_range(32'h7000_0000) - 32'h3800_0000;
    w.slon = $urandom;
    w.elat = w.slat + $urandom_range(span) - span / 2;
    w.elon = w.slon + $urandom_range(span) - span / 2;
    w.plat = w.slat + $urandom_range(span) - span / 2;
    w.plon = w.slon + $urandom_range(span) - span / 2;
    return w;
  endfunction

  // Extremes, coincident points, both sides of a path and out-of-range latitudes.
  task automatic test_directed();
    send_word(mk(0, 0, 0, 0, 0, 0));
    send_word(mk(0, 0, 0, 32'h0100_0000, 32'h0010_0000, 32'h0080_0000));
    send_word(mk(0, 0, 0, 32'h0100_0000, -32'sh0010_0000, 32'h0080_0000));
    send_word(mk(0, 0, 32'h0100_0000, 0, 32'h0080_0000, 32'h0010_0000));
    send_word(mk(32'h1000_0000, 32'h2000_0000, 32'h1000_0000, 32'h2000_0000,
                 32'h1100_0000, 32'h2100_0000));
    send_word(mk(32'h1000_0000, 32'h2000_0000, 32'h1200_0000, 32'h2200_0000,
                 32'h1000_0000, 32'h2000_0000));
    send_word(mk(DEG180, DEG180, DEG180, DEG180, DEG180, DEG180));
    send_word(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_word(mk(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, DEG180, DEG180, 32'h7FFF_FFFF));
    send_word(mk(DEG90, 0, 0, 0, 0, DEG90));
    send_word(mk(-DEG90, 0, 0, 32'h1000_0000, DEG90, 0));
    send_word(mk(0, 0, 0, DEG90, DEG90, 0));
    send_word(mk(0, 0, 0, DEG90, -DEG90, 0));
    send_word(mk(0, 0, 0, DEG90, 0, DEG180));
    send_word(mk(32'h5000_0000, 32'h1000_0000, 32'h6000_0000, 32'h2000_0000,
                 32'hA000_0000, 32'h3000_0000));
    send_word(mk(32'h6000_0000, 0, 32'hA000_0000, DEG90, 32'hB000_0000, DEG180));
    send_word(mk(0, 0, 0, 32'h0000_0001, 32'h0000_0001, 0));
    send_word(mk(0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 0));
    send_word(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC,
                 32'h0F0F_0F0F, 32'hF0F0_F0F0));
    wait_drained();
  endtask

  task automatic test_random(int count, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < count; i++) send_word(random_track());
    wait_drained();
  endtask

  // Long result-side hold while words keep coming, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 400;
    for (int i = 0; i < 300; i++) send_word(random_track());
    wait_drained();
  endtask

  task automatic test_radius_sweep();
    write_radius(24'd0);
    test_directed();
    write_radius(24'hFF_FFFF);
    test_directed();
    test_random(500, 34, 53);
    write_radius(24'd1);
    test_random(500, 53, 34);
    write_radius(24'($urandom_range(24'hFF_FFFF, 1)));
    test_random(310, 0, 0);
    write_radius(RADIUS_RST);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_radius_sweep();
    test_backpressure();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d words, %0d results and %0d radius writes", n_words, n_results,
             n_cfg);
    $display("including zero, unit and full-scale radius and a long output hold");
    if (n_errors == 0 && xt_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far above the slowest legal run.
  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

endmodule
